[rtl/sfd_pkg.sv]
// Shared types and constants for the signed fixed-point digit add/subtract unit.
// Used by the channel interfaces, the digit lanes, the merge stage and the top level.
`timescale 1ns / 1ps

package sfd_pkg;

    // Fixed widths of the fields on the channels and of the length count, and the reset radix.
    localparam int FIELD_W    = 40;
    localparam int LEN_W      = 4;
    localparam int BASE_W     = 5;
    localparam int LEN_CALC_W = 5;
    localparam int BASE_RESET = 10;

    // Operation codes carried in the cmd field.
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // Carry and borrow outputs of one digit lane, for carry-in 0 and carry-in 1.
    typedef struct packed {
        logic add_c0;
        logic add_c1;
        logic ab_b0;
        logic ab_b1;
        logic ba_b0;
        logic ba_b1;
    } lane_carry_t;

    // Per-item control that travels beside the lane results.
    typedef struct packed {
        logic eff_sub;
        logic sign_a;
        logic sign_b;
    } item_ctl_t;

endpackage

[rtl/sfd_ifs.sv]
// Valid/ready channel interfaces: configuration writes, operand items and result items.
// Depends on sfd_pkg for the field widths.
`timescale 1ns / 1ps

interface sfd_cfg_if;
    import sfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] digit_base;

    modport source (output valid, output digit_base, input ready);
    modport sink   (input valid, input digit_base, output ready);
endinterface

interface sfd_op_if;
    import sfd_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic               sign_a;
    logic [FIELD_W-1:0] a_int_digits;
    logic [FIELD_W-1:0] a_frac_digits;
    logic               sign_b;
    logic [FIELD_W-1:0] b_int_digits;
    logic [FIELD_W-1:0] b_frac_digits;

    modport source (output valid, output cmd, output sign_a, output a_int_digits,
                    output a_frac_digits, output sign_b, output b_int_digits,
                    output b_frac_digits, input ready);
    modport sink   (input valid, input cmd, input sign_a, input a_int_digits,
                    input a_frac_digits, input sign_b, input b_int_digits,
                    input b_frac_digits, output ready);
endinterface

interface sfd_res_if;
    import sfd_pkg::*;

    logic               valid;
    logic               ready;
    logic               sign_r;
    logic [FIELD_W-1:0] r_int_digits;
    logic [FIELD_W-1:0] r_frac_digits;
    logic [LEN_W-1:0]   int_length;
    logic [LEN_W-1:0]   frac_length;
    logic               overflow;

    modport source (output valid, output sign_r, output r_int_digits, output r_frac_digits,
                    output int_length, output frac_length, output overflow, input ready);
    modport sink   (input valid, input sign_r, input r_int_digits, input r_frac_digits,
                    input int_length, input frac_length, input overflow, output ready);
endinterface

[rtl/sfd_lane.sv]
// One digit lane: saturates both input digits and precomputes sum, A-B and B-A
// for carry/borrow-in 0 and 1, registered. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_lane #(
    parameter int DIGIT_BITS = 4
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [DIGIT_BITS-1:0]   a_raw,
    input  logic [DIGIT_BITS-1:0]   b_raw,
    input  logic [DIGIT_BITS:0]     base,
    output logic [DIGIT_BITS-1:0]   add0,
    output logic [DIGIT_BITS-1:0]   add1,
    output logic [DIGIT_BITS-1:0]   ab0,
    output logic [DIGIT_BITS-1:0]   ab1,
    output logic [DIGIT_BITS-1:0]   ba0,
    output logic [DIGIT_BITS-1:0]   ba1,
    output sfd_pkg::lane_carry_t    carry
);
    import sfd_pkg::*;

    localparam int BW = DIGIT_BITS + 1;
    localparam int SW = BW + 1;

    logic [BW-1:0]         a_sat, b_sat;
    logic [SW-1:0]         base_w, s0, s1;
    logic                  c0, c1;
    logic [DIGIT_BITS:0]   d_ab0, d_ab1, d_ba0, d_ba1;

    logic [DIGIT_BITS-1:0] add0_reg, add1_reg, ab0_reg, ab1_reg, ba0_reg, ba1_reg;
    lane_carry_t           carry_reg;

    // Returns {borrow_out, digit} of x - y - bin in the current radix.
    function automatic logic [DIGIT_BITS:0] sub_digit(input logic [BW-1:0] x,
                                                      input logic [BW-1:0] y,
                                                      input logic bin,
                                                      input logic [SW-1:0] bs);
        logic [SW-1:0] t;
        logic [SW-1:0] d;
        logic          bo;
        t  = SW'(y) + SW'(bin);
        bo = SW'(x) < t;
        d  = bo ? (SW'(x) + bs - t) : (SW'(x) - t);
        return {bo, d[DIGIT_BITS-1:0]};
    endfunction

    always_comb
    begin
        a_sat  = (BW'(a_raw) >= base) ? (base - BW'(1)) : BW'(a_raw);
        b_sat  = (BW'(b_raw) >= base) ? (base - BW'(1)) : BW'(b_raw);
        base_w = SW'(base);
        s0     = SW'(a_sat) + SW'(b_sat);
        s1     = s0 + SW'(1);
        c0     = s0 >= base_w;
        c1     = s1 >= base_w;
        d_ab0  = sub_digit(a_sat, b_sat, 1'b0, base_w);
        d_ab1  = sub_digit(a_sat, b_sat, 1'b1, base_w);
        d_ba0  = sub_digit(b_sat, a_sat, 1'b0, base_w);
        d_ba1  = sub_digit(b_sat, a_sat, 1'b1, base_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            add0_reg        <= DIGIT_BITS'(c0 ? (s0 - base_w) : s0);
            add1_reg        <= DIGIT_BITS'(c1 ? (s1 - base_w) : s1);
            ab0_reg         <= d_ab0[DIGIT_BITS-1:0];
            ab1_reg         <= d_ab1[DIGIT_BITS-1:0];
            ba0_reg         <= d_ba0[DIGIT_BITS-1:0];
            ba1_reg         <= d_ba1[DIGIT_BITS-1:0];
            carry_reg.add_c0 <= c0;
            carry_reg.add_c1 <= c1;
            carry_reg.ab_b0  <= d_ab0[DIGIT_BITS];
            carry_reg.ab_b1  <= d_ab1[DIGIT_BITS];
            carry_reg.ba_b0  <= d_ba0[DIGIT_BITS];
            carry_reg.ba_b1  <= d_ba1[DIGIT_BITS];
        end
    end

    assign add0  = add0_reg;
    assign add1  = add1_reg;
    assign ab0   = ab0_reg;
    assign ab1   = ab1_reg;
    assign ba0   = ba0_reg;
    assign ba1   = ba1_reg;
    assign carry = carry_reg;

endmodule

[rtl/sfd_merge.sv]
// Merge stage: resolves lane carries and borrows with one prefix add per path,
// selects the result digits, packs them and finds sign and used lengths. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_merge #(
    parameter int DIGITS     = 10,
    parameter int DIGIT_BITS = 4
) (
    input  logic                           clk,
    input  logic                           en,
    input  sfd_pkg::item_ctl_t             ctl,
    input  logic [DIGIT_BITS-1:0]          add0 [2*DIGITS],
    input  logic [DIGIT_BITS-1:0]          add1 [2*DIGITS],
    input  logic [DIGIT_BITS-1:0]          ab0  [2*DIGITS],
    input  logic [DIGIT_BITS-1:0]          ab1  [2*DIGITS],
    input  logic [DIGIT_BITS-1:0]          ba0  [2*DIGITS],
    input  logic [DIGIT_BITS-1:0]          ba1  [2*DIGITS],
    input  sfd_pkg::lane_carry_t           carry [2*DIGITS],
    output logic                           sign_r,
    output logic [sfd_pkg::FIELD_W-1:0]    r_int_digits,
    output logic [sfd_pkg::FIELD_W-1:0]    r_frac_digits,
    output logic [sfd_pkg::LEN_W-1:0]      int_length,
    output logic [sfd_pkg::LEN_W-1:0]      frac_length,
    output logic                           overflow
);
    import sfd_pkg::*;

    localparam int N2 = 2 * DIGITS;
    localparam int PW = DIGITS * DIGIT_BITS;
    localparam int EW = (PW > FIELD_W) ? PW : FIELD_W;

    logic [N2-1:0]         add_g0, add_g1, ab_g0, ab_g1, ba_g0, ba_g1;
    logic [N2:0]           add_sum, ab_sum, ba_sum;
    logic [N2-1:0]         add_cin, ab_cin, ba_cin;
    logic                  b_larger, is_zero, sign_sel;
    logic [DIGIT_BITS-1:0] dig [N2];
    logic [EW-1:0]         int_vec, frac_vec;
    logic [LEN_CALC_W-1:0] int_len, frac_len;

    logic                  sign_r_reg, overflow_reg;
    logic [FIELD_W-1:0]    r_int_reg, r_frac_reg;
    logic [LEN_W-1:0]      int_len_reg, frac_len_reg;

    always_comb
    begin
        for (int j = 0; j < N2; j++)
        begin
            add_g0[j] = carry[j].add_c0;
            add_g1[j] = carry[j].add_c1;
            ab_g0[j]  = carry[j].ab_b0;
            ab_g1[j]  = carry[j].ab_b1;
            ba_g0[j]  = carry[j].ba_b0;
            ba_g1[j]  = carry[j].ba_b1;
        end
    end

    // A lane that carries with carry-in 0 also carries with carry-in 1, so the carry
    // into each lane is the internal carry of the binary sum of the two vectors.
    assign add_sum = {1'b0, add_g0} + {1'b0, add_g1};
    assign ab_sum  = {1'b0, ab_g0} + {1'b0, ab_g1};
    assign ba_sum  = {1'b0, ba_g0} + {1'b0, ba_g1};
    assign add_cin = add_sum[N2-1:0] ^ add_g0 ^ add_g1;
    assign ab_cin  = ab_sum[N2-1:0] ^ ab_g0 ^ ab_g1;
    assign ba_cin  = ba_sum[N2-1:0] ^ ba_g0 ^ ba_g1;

    // A borrow out of A-B means the magnitude of B is the larger one.
    assign b_larger = ab_sum[N2];

    always_comb
    begin
        for (int j = 0; j < N2; j++)
        begin
            if (!ctl.eff_sub)
                dig[j] = add_cin[j] ? add1[j] : add0[j];
            else if (b_larger)
                dig[j] = ba_cin[j] ? ba1[j] : ba0[j];
            else
                dig[j] = ab_cin[j] ? ab1[j] : ab0[j];
        end
    end

    // Lanes run from the last fraction digit up to the top integer digit.
    always_comb
    begin
        int_vec  = '0;
        frac_vec = '0;
        is_zero  = 1'b1;
        int_len  = LEN_CALC_W'(1);
        frac_len = LEN_CALC_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            int_vec[i*DIGIT_BITS +: DIGIT_BITS]  = dig[DIGITS + i];
            frac_vec[i*DIGIT_BITS +: DIGIT_BITS] = dig[DIGITS - 1 - i];
            if (dig[DIGITS + i] != '0)
                int_len = LEN_CALC_W'(i + 1);
            if (dig[DIGITS - 1 - i] != '0)
                frac_len = LEN_CALC_W'(i + 1);
        end
        for (int j = 0; j < N2; j++)
        begin
            if (dig[j] != '0)
                is_zero = 1'b0;
        end
        sign_sel = (ctl.eff_sub && b_larger) ? ctl.sign_b : ctl.sign_a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_r_reg   <= sign_sel & ~is_zero;
            r_int_reg    <= int_vec[FIELD_W-1:0];
            r_frac_reg   <= frac_vec[FIELD_W-1:0];
            int_len_reg  <= int_len[LEN_W-1:0];
            frac_len_reg <= frac_len[LEN_W-1:0];
            overflow_reg <= ~ctl.eff_sub & add_sum[N2];
        end
    end

    assign sign_r        = sign_r_reg;
    assign r_int_digits  = r_int_reg;
    assign r_frac_digits = r_frac_reg;
    assign int_length    = int_len_reg;
    assign frac_length   = frac_len_reg;
    assign overflow      = overflow_reg;

endmodule

[rtl/signed_fixed_digit_add_sub_unit.sv]
// Top level of the signed fixed-point digit add/subtract unit: radix register,
// digit lanes, merge stage and pipeline control. Depends on sfd_pkg, sfd_ifs, sfd_lane, sfd_merge.
`timescale 1ns / 1ps

// Usage:
//   cfg  - write channel for the digit radix. Always ready; a transfer takes effect
//          on the next item. Values below 2 act as 2, values above 2^DIGIT_BITS as
//          2^DIGIT_BITS. Write it only while no item is in flight.
//   op   - operand items: command, two signs and the integer/fraction digit vectors.
//   res  - one result item per operand item, in order.
// An item transferred on op is registered first in the lane stage and then in the merge
// stage's output register, which shows it on res until it transfers out. One lane per
// digit position registers the digit-wise sums and differences, and the merge stage
// registers the result, so while res does not stall one item is taken per cycle.
// When res stalls, the output register holds its item and the lane stage still takes
// one more item; op.ready drops only when both stages are full.
// Reset clears both valid flags and sets the radix to ten (2^DIGIT_BITS if smaller).
module signed_fixed_digit_add_sub_unit #(
    parameter int DIGITS     = 10,
    parameter int DIGIT_BITS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    sfd_cfg_if.sink   cfg,
    sfd_op_if.sink    op,
    sfd_res_if.source res
);
    import sfd_pkg::*;

    localparam int N2       = 2 * DIGITS;
    localparam int BW       = DIGIT_BITS + 1;
    localparam int CW       = (BW > BASE_W) ? BW : BASE_W;
    localparam int PW       = DIGITS * DIGIT_BITS;
    localparam int EW       = (PW > FIELD_W) ? PW : FIELD_W;
    localparam int TOP_BASE = 1 << DIGIT_BITS;
    localparam int RST_BASE = (BASE_RESET > TOP_BASE) ? TOP_BASE : BASE_RESET;

    logic [BW-1:0]         base_reg, base_next;
    logic [CW-1:0]         base_wr;
    logic                  lane_valid_reg, lane_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_adv, take;
    item_ctl_t             ctl_reg;

    logic [EW-1:0]         a_int_ext, a_frac_ext, b_int_ext, b_frac_ext;
    logic [DIGIT_BITS-1:0] a_dig [N2];
    logic [DIGIT_BITS-1:0] b_dig [N2];
    logic [DIGIT_BITS-1:0] add0 [N2];
    logic [DIGIT_BITS-1:0] add1 [N2];
    logic [DIGIT_BITS-1:0] ab0  [N2];
    logic [DIGIT_BITS-1:0] ab1  [N2];
    logic [DIGIT_BITS-1:0] ba0  [N2];
    logic [DIGIT_BITS-1:0] ba1  [N2];
    lane_carry_t           carry [N2];

    // Radix register, clamped when written.
    always_comb
    begin
        base_wr = CW'(cfg.digit_base);
        if (base_wr < CW'(2))
            base_next = BW'(2);
        else if (base_wr > CW'(TOP_BASE))
            base_next = BW'(TOP_BASE);
        else
            base_next = base_wr[BW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BW'(RST_BASE);
        else if (cfg.valid && cfg.ready)
            base_reg <= base_next;
    end

    assign cfg.ready = 1'b1;

    // Two-stage pipeline control: lane stage, then output register.
    assign out_adv  = ~out_valid_reg | res.ready;
    assign op.ready = ~lane_valid_reg | out_adv;
    assign take     = op.valid & op.ready;

    always_comb
    begin
        lane_valid_next = op.ready ? op.valid : lane_valid_reg;
        out_valid_next  = out_adv ? lane_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg.eff_sub <= op.sign_a ^ op.sign_b ^ (op.cmd == CMD_SUB);
            ctl_reg.sign_a  <= op.sign_a;
            ctl_reg.sign_b  <= op.sign_b ^ (op.cmd == CMD_SUB);
        end
    end

    assign a_int_ext  = EW'(op.a_int_digits);
    assign a_frac_ext = EW'(op.a_frac_digits);
    assign b_int_ext  = EW'(op.b_int_digits);
    assign b_frac_ext = EW'(op.b_frac_digits);

    // Lane j below DIGITS holds fraction digit DIGITS-1-j; the rest hold integer digits.
    for (genvar j = 0; j < N2; j++)
    begin : g_lane
        if (j < DIGITS)
        begin : g_frac
            assign a_dig[j] = a_frac_ext[(DIGITS-1-j)*DIGIT_BITS +: DIGIT_BITS];
            assign b_dig[j] = b_frac_ext[(DIGITS-1-j)*DIGIT_BITS +: DIGIT_BITS];
        end
        else
        begin : g_int
            assign a_dig[j] = a_int_ext[(j-DIGITS)*DIGIT_BITS +: DIGIT_BITS];
            assign b_dig[j] = b_int_ext[(j-DIGITS)*DIGIT_BITS +: DIGIT_BITS];
        end

        sfd_lane #(
            .DIGIT_BITS (DIGIT_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (take),
            .a_raw (a_dig[j]),
            .b_raw (b_dig[j]),
            .base  (base_reg),
            .add0  (add0[j]),
            .add1  (add1[j]),
            .ab0   (ab0[j]),
            .ab1   (ab1[j]),
            .ba0   (ba0[j]),
            .ba1   (ba1[j]),
            .carry (carry[j])
        );
    end

    sfd_merge #(
        .DIGITS     (DIGITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_merge (
        .clk           (clk),
        .en            (out_adv & lane_valid_reg),
        .ctl           (ctl_reg),
        .add0          (add0),
        .add1          (add1),
        .ab0           (ab0),
        .ab1           (ab1),
        .ba0           (ba0),
        .ba1           (ba1),
        .carry         (carry),
        .sign_r        (res.sign_r),
        .r_int_digits  (res.r_int_digits),
        .r_frac_digits (res.r_frac_digits),
        .int_length    (res.int_length),
        .frac_length   (res.frac_length),
        .overflow      (res.overflow)
    );

    assign res.valid = out_valid_reg;

endmodule

[rtl/sfd_checker.sv]
// Port-level checks for the signed fixed-point digit add/subtract unit,
// attached to the top level by the bind at the end. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         op_valid,
    input logic                         op_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         sign_r,
    input logic [sfd_pkg::FIELD_W-1:0]  r_int_digits,
    input logic [sfd_pkg::FIELD_W-1:0]  r_frac_digits,
    input logic [sfd_pkg::LEN_W-1:0]    int_length,
    input logic [sfd_pkg::LEN_W-1:0]    frac_length,
    input logic                         overflow
);
    import sfd_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       op_xfer, res_xfer;

    assign op_xfer  = op_valid & op_ready;
    assign res_xfer = res_valid & res_ready;

    // Items transferred in but not yet transferred out.
    always_comb
    begin
        pending_next = pending_reg + 2'(op_xfer) - 2'(res_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(sign_r) && $stable(r_int_digits)
            && $stable(r_frac_digits) && $stable(int_length) && $stable(frac_length)
            && $stable(overflow))
        else $error("result changed while stalled");

    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && r_int_digits == '0 && r_frac_digits == '0 |-> !sign_r)
        else $error("zero result carries a negative sign");

    // With the output register empty the unit must take a new item.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> op_ready)
        else $error("input stalled with empty output register");

    // At most two items in flight, and a result never appears without one.
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3 && (!res_valid || pending_reg != 2'd0))
        else $error("item count between input and output is inconsistent");

endmodule

bind signed_fixed_digit_add_sub_unit sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (op.valid),
    .op_ready      (op.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .sign_r        (res.sign_r),
    .r_int_digits  (res.r_int_digits),
    .r_frac_digits (res.r_frac_digits),
    .int_length    (res.int_length),
    .frac_length   (res.frac_length),
    .overflow      (res.overflow)
);
